FILE: src/mpw_pkg.sv
package mpw_pkg;

  localparam int WIDTH = 16;
  localparam int CNT_W = $clog2(WIDTH + 1);
  localparam int PC_W  = 4;

  typedef struct packed {
    logic [WIDTH-1:0] base;
    logic [WIDTH-1:0] exponent;
    logic [WIDTH-1:0] modulus;
  } in_t;

  typedef struct packed {
    logic [WIDTH-1:0] power;
    logic             zero_modulus;
  } out_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_DIV_STEP,
    OP_POW_INIT,
    OP_LOAD_ACC,
    OP_LOAD_SQ,
    OP_MUL_STEP,
    OP_STORE_ACC,
    OP_STORE_SQ,
    OP_SHIFT_E,
    OP_SET_ONE,
    OP_SET_ZERO,
    OP_EMIT
  } op_t;

  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_E_ZERO,
    C_M_ZERO,
    C_CNT_MORE,
    C_E_BIT_CLR,
    C_E_LAST,
    C_Y_MORE
  } cond_t;

  typedef struct packed {
    op_t             op;
    cond_t           cond;
    logic [PC_W-1:0] target;
    logic            last;
  } uword_t;

  typedef struct packed {
    logic e_zero;
    logic m_zero;
    logic cnt_more;
    logic e_bit;
    logic e_last;
    logic y_more;
    logic out_busy;
  } status_t;

endpackage

FILE: src/mpw_sequencer.sv
module mpw_sequencer
  import mpw_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  status_t status,
  output logic    busy,
  output uword_t  word
);

  localparam logic [PC_W-1:0] S_CHK_E    = 4'd0;
  localparam logic [PC_W-1:0] S_CHK_M    = 4'd1;
  localparam logic [PC_W-1:0] S_DIV      = 4'd2;
  localparam logic [PC_W-1:0] S_INIT     = 4'd3;
  localparam logic [PC_W-1:0] S_TOP      = 4'd4;
  localparam logic [PC_W-1:0] S_LD_ACC   = 4'd5;
  localparam logic [PC_W-1:0] S_MUL_ACC  = 4'd6;
  localparam logic [PC_W-1:0] S_ST_ACC   = 4'd7;
  localparam logic [PC_W-1:0] S_SHIFT    = 4'd8;
  localparam logic [PC_W-1:0] S_LD_SQ    = 4'd9;
  localparam logic [PC_W-1:0] S_MUL_SQ   = 4'd10;
  localparam logic [PC_W-1:0] S_ST_SQ    = 4'd11;
  localparam logic [PC_W-1:0] S_FINISH   = 4'd12;
  localparam logic [PC_W-1:0] S_ONE      = 4'd13;
  localparam logic [PC_W-1:0] S_ZERO     = 4'd14;

  logic [PC_W-1:0] pc;
  logic [PC_W-1:0] pc_next;
  logic            busy_next;
  uword_t          rom;
  logic            taken;

  // microprogram
  always_comb begin
    unique case (pc)
      S_CHK_E:   rom = '{OP_NOP,       C_E_ZERO,    S_ONE,     1'b0};
      S_CHK_M:   rom = '{OP_NOP,       C_M_ZERO,    S_ZERO,    1'b0};
      S_DIV:     rom = '{OP_DIV_STEP,  C_CNT_MORE,  S_DIV,     1'b0};
      S_INIT:    rom = '{OP_POW_INIT,  C_NEVER,     S_CHK_E,   1'b0};
      S_TOP:     rom = '{OP_NOP,       C_E_BIT_CLR, S_SHIFT,   1'b0};
      S_LD_ACC:  rom = '{OP_LOAD_ACC,  C_NEVER,     S_CHK_E,   1'b0};
      S_MUL_ACC: rom = '{OP_MUL_STEP,  C_Y_MORE,    S_MUL_ACC, 1'b0};
      S_ST_ACC:  rom = '{OP_STORE_ACC, C_NEVER,     S_CHK_E,   1'b0};
      S_SHIFT:   rom = '{OP_SHIFT_E,   C_E_LAST,    S_FINISH,  1'b0};
      S_LD_SQ:   rom = '{OP_LOAD_SQ,   C_NEVER,     S_CHK_E,   1'b0};
      S_MUL_SQ:  rom = '{OP_MUL_STEP,  C_Y_MORE,    S_MUL_SQ,  1'b0};
      S_ST_SQ:   rom = '{OP_STORE_SQ,  C_ALWAYS,    S_TOP,     1'b0};
      S_FINISH:  rom = '{OP_EMIT,      C_NEVER,     S_FINISH,  1'b1};
      S_ONE:     rom = '{OP_SET_ONE,   C_ALWAYS,    S_FINISH,  1'b0};
      S_ZERO:    rom = '{OP_SET_ZERO,  C_ALWAYS,    S_FINISH,  1'b0};
      default:   rom = '{OP_NOP,       C_NEVER,     S_CHK_E,   1'b1};
    endcase
  end

  always_comb begin
    unique case (rom.cond)
      C_NEVER:     taken = 1'b0;
      C_ALWAYS:    taken = 1'b1;
      C_E_ZERO:    taken = status.e_zero;
      C_M_ZERO:    taken = status.m_zero;
      C_CNT_MORE:  taken = status.cnt_more;
      C_E_BIT_CLR: taken = !status.e_bit;
      C_E_LAST:    taken = status.e_last;
      C_Y_MORE:    taken = status.y_more;
      default:     taken = 1'b0;
    endcase
  end

  // emit holds while the output slot is full
  always_comb begin
    pc_next   = pc;
    busy_next = busy;
    if (!busy) begin
      if (start) begin
        busy_next = 1'b1;
        pc_next   = S_CHK_E;
      end
    end else if (rom.op == OP_EMIT && status.out_busy) begin
      pc_next = pc;
    end else if (taken) begin
      pc_next = rom.target;
    end else if (rom.last) begin
      busy_next = 1'b0;
      pc_next   = S_CHK_E;
    end else begin
      pc_next = pc + PC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pc   <= S_CHK_E;
    end else begin
      busy <= busy_next;
      pc   <= pc_next;
    end
  end

  always_comb begin
    word = rom;
    if (!busy) word.op = OP_NOP;
  end

  a_start_at_top: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> pc == S_CHK_E)
    else $error("program did not start at first step");

  a_emit_ends: assert property (@(posedge clk) disable iff (rst)
    busy && word.op == OP_EMIT && !status.out_busy |=> !busy)
    else $error("sequencer stayed busy after emit");

  a_idle_no_op: assert property (@(posedge clk) disable iff (rst)
    !busy |-> word.op == OP_NOP)
    else $error("datapath op issued while idle");

endmodule

FILE: src/mpw_datapath.sv
module mpw_datapath
  import mpw_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  in_t     in_data,
  input  op_t     op,
  output status_t status,
  output logic    out_valid,
  input  logic    out_ready,
  output out_t    out_data
);

  logic [WIDTH-1:0] x;
  logic [WIDTH-1:0] y;
  logic [WIDTH-1:0] p;
  logic [WIDTH-1:0] acc;
  logic [WIDTH-1:0] sq;
  logic [WIDTH-1:0] e;
  logic [WIDTH-1:0] m;
  logic [CNT_W-1:0] cnt;
  logic             flag;

  logic [WIDTH:0]   div_t_val;
  logic [WIDTH-1:0] div_rem;
  logic [WIDTH-1:0] p_add;
  logic [WIDTH-1:0] x_dbl;
  logic             emit;

  // (a + b) mod m for a, b below m
  function automatic logic [WIDTH-1:0] add_mod(input logic [WIDTH-1:0] a,
                                               input logic [WIDTH-1:0] b,
                                               input logic [WIDTH-1:0] md);
    logic [WIDTH-1:0] room;
    room = md - b;
    if (a >= room) return a - room;
    return a + b;
  endfunction

  // restoring division step, one base bit a beat
  always_comb begin
    div_t_val = {p, x[WIDTH-1]};
    if (div_t_val >= {1'b0, m}) div_rem = WIDTH'(div_t_val - {1'b0, m});
    else                        div_rem = div_t_val[WIDTH-1:0];
  end

  assign p_add = add_mod(p, x, m);
  assign x_dbl = add_mod(x, x, m);

  assign status.out_busy = out_valid && !out_ready;
  assign status.e_zero   = e == '0;
  assign status.m_zero   = m == '0;
  assign status.cnt_more = cnt != CNT_W'(1);
  assign status.e_bit    = e[0];
  assign status.e_last   = e[WIDTH-1:1] == '0;
  assign status.y_more   = y[WIDTH-1:1] != '0;

  assign emit = op == OP_EMIT && !status.out_busy;

  always_ff @(posedge clk) begin
    if (load) begin
      x    <= in_data.base;
      e    <= in_data.exponent;
      m    <= in_data.modulus;
      p    <= '0;
      cnt  <= CNT_W'(WIDTH);
      flag <= 1'b0;
    end else begin
      unique case (op)
        OP_NOP: begin
        end
        OP_DIV_STEP: begin
          p   <= div_rem;
          x   <= {x[WIDTH-2:0], 1'b0};
          cnt <= cnt - CNT_W'(1);
        end
        OP_POW_INIT: begin
          sq  <= p;
          acc <= (m == WIDTH'(1)) ? '0 : WIDTH'(1);
        end
        OP_LOAD_ACC: begin
          x <= acc;
          y <= sq;
          p <= '0;
        end
        OP_LOAD_SQ: begin
          x <= sq;
          y <= sq;
          p <= '0;
        end
        OP_MUL_STEP: begin
          if (y[0]) p <= p_add;
          x <= x_dbl;
          y <= {1'b0, y[WIDTH-1:1]};
        end
        OP_STORE_ACC: acc <= p;
        OP_STORE_SQ:  sq  <= p;
        OP_SHIFT_E:   e   <= {1'b0, e[WIDTH-1:1]};
        OP_SET_ONE: begin
          acc  <= WIDTH'(1);
          flag <= 1'b0;
        end
        OP_SET_ZERO: begin
          acc  <= '0;
          flag <= 1'b1;
        end
        OP_EMIT: begin
          if (emit) begin
            out_data.power        <= acc;
            out_data.zero_modulus <= flag;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  a_flag_zero_power: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.zero_modulus |-> out_data.power == '0)
    else $error("zero modulus beat with nonzero power");

  a_mul_reduced: assert property (@(posedge clk) disable iff (rst)
    op == OP_MUL_STEP |-> x < m && p < m)
    else $error("multiplier operand not reduced");

  a_emit_fills: assert property (@(posedge clk) disable iff (rst)
    emit |=> out_valid && out_data.power == $past(acc))
    else $error("emit did not fill output slot");

endmodule

FILE: src/modular_power.sv
// A zero exponent gives one; else a zero modulus gives zero, flagged. Else the
// base is reduced by restoring division and the exponent walked bit by bit on
// the shared shift-add modular multiplier (one multiplier bit a cycle). A new
// request is taken only once the result is emitted; output stalls hold the
// emit step.
// Reset (rst, synchronous): sequencer idle at its first step, output empty.
module modular_power
  import mpw_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  logic    busy;
  logic    load;
  uword_t  word;
  status_t status;

  assign in_ready = !busy;
  assign load     = in_valid && in_ready;

  mpw_sequencer u_seq (
    .clk    (clk),
    .rst    (rst),
    .start  (load),
    .status (status),
    .busy   (busy),
    .word   (word)
  );

  mpw_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .load      (load),
    .in_data   (in_data),
    .op        (word.op),
    .status    (status),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
